// ===== hw/rtl/vector_to_yaw_pitch_macros.svh =====
// assertion macros for the vector_to_yaw_pitch checker
// expects clk and rst_n in the scope where a macro is used
`ifndef VECTOR_TO_YAW_PITCH_MACROS_SVH
`define VECTOR_TO_YAW_PITCH_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define VTYP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_to_yaw_pitch: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define VTYP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector_to_yaw_pitch: next-cycle check failed");

`endif

// ===== hw/rtl/vtyp_pkg.sv =====
// shared types, constants and angle helpers for vector_to_yaw_pitch
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vtyp_pkg;

  // port field widths
  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 25;

  // defaults for the top level parameters
  localparam int unsigned COMPONENT_BITS_DEF = 24;
  localparam int unsigned CORDIC_STAGES_DEF  = 20;

  // fixed point formats
  localparam int unsigned GUARD_SHIFT = 4;
  localparam int unsigned ANG_FRAC    = 20;
  localparam int unsigned OUT_FRAC    = 16;
  localparam int unsigned ANG_W       = 31;
  localparam int unsigned ATAN_W      = 26;
  localparam int unsigned A_W         = ANG_W + 1 - (ANG_FRAC - OUT_FRAC);

  // inverse cordic gain, q24
  localparam int unsigned GAIN_FRAC = 24;
  localparam int unsigned GAIN_W    = 24;
  localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(10188014);

  // angle constants
  localparam logic signed [ANG_W-1:0] ANG_180    = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] ANG_ROUND  = ANG_W'(1 << (ANG_FRAC - OUT_FRAC - 1));
  localparam logic [OUT_W-1:0]        DEG_90     = OUT_W'(90 << OUT_FRAC);
  localparam logic [OUT_W-1:0]        DEG_180    = OUT_W'(180 << OUT_FRAC);
  localparam logic [OUT_W-1:0]        DEG_270    = OUT_W'(270 << OUT_FRAC);
  localparam logic [OUT_W-1:0]        FULL_TURN_OUT = OUT_W'(360 << OUT_FRAC);
  localparam logic signed [A_W-1:0]   FULL_TURN_A   = A_W'(360 << OUT_FRAC);

  typedef struct packed {
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] yaw_deg;
    logic [OUT_W-1:0] pitch_deg;
  } out_beat_t;

  // atan(2^-i) in degrees, q20
  function automatic logic [ATAN_W-1:0] atan_q20(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = ATAN_W'(47185920);
      5'd1:    v = ATAN_W'(27855475);
      5'd2:    v = ATAN_W'(14718068);
      5'd3:    v = ATAN_W'(7471121);
      5'd4:    v = ATAN_W'(3750058);
      5'd5:    v = ATAN_W'(1876857);
      5'd6:    v = ATAN_W'(938658);
      5'd7:    v = ATAN_W'(469357);
      5'd8:    v = ATAN_W'(234682);
      5'd9:    v = ATAN_W'(117342);
      5'd10:   v = ATAN_W'(58671);
      5'd11:   v = ATAN_W'(29335);
      5'd12:   v = ATAN_W'(14668);
      5'd13:   v = ATAN_W'(7334);
      5'd14:   v = ATAN_W'(3667);
      5'd15:   v = ATAN_W'(1833);
      5'd16:   v = ATAN_W'(917);
      5'd17:   v = ATAN_W'(458);
      5'd18:   v = ATAN_W'(229);
      5'd19:   v = ATAN_W'(115);
      5'd20:   v = ATAN_W'(57);
      5'd21:   v = ATAN_W'(29);
      5'd22:   v = ATAN_W'(14);
      5'd23:   v = ATAN_W'(7);
      5'd24:   v = ATAN_W'(4);
      5'd25:   v = ATAN_W'(2);
      5'd26:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round q20 angle to q16 and wrap into one turn
  function automatic logic [OUT_W-1:0] finish_angle(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W:0]  t;
    logic signed [A_W-1:0]  a;
    logic signed [A_W-1:0]  w;
    t = {ang[ANG_W-1], ang} + {ANG_ROUND[ANG_W-1], ANG_ROUND};
    a = t[ANG_W:ANG_FRAC-OUT_FRAC];
    if (a < 0) begin
      w = a + FULL_TURN_A;
    end else if (a >= FULL_TURN_A) begin
      w = a - FULL_TURN_A;
    end else begin
      w = a;
    end
    if (w < 0 || w >= FULL_TURN_A) begin
      w = '0;
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vtyp_cordic_stage.sv =====
// one registered cordic vectoring iteration with a fixed shift
// depends on vtyp_pkg (angle width, arctangent table)
`timescale 1ns / 1ps
`default_nettype none

module vtyp_cordic_stage
  import vtyp_pkg::*;
#(
  parameter int unsigned CW    = 31,
  parameter int unsigned SW    = 1,
  parameter int unsigned SHIFT = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  logic signed [CW-1:0]    x_i,
  input  logic signed [CW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] ang_i,
  input  logic [SW-1:0]           side_i,
  output logic                    valid_o,
  output logic signed [CW-1:0]    x_o,
  output logic signed [CW-1:0]    y_o,
  output logic signed [ANG_W-1:0] ang_o,
  output logic [SW-1:0]           side_o
);

  logic                    valid_r;
  logic signed [CW-1:0]    x_r, y_r, x_nxt, y_nxt;
  logic signed [ANG_W-1:0] ang_r, ang_nxt;
  logic [SW-1:0]           side_r;
  logic signed [CW-1:0]    xs, ys;
  logic signed [ANG_W-1:0] step;

  // rotate toward the x axis, direction from the sign of y
  always_comb begin
    xs   = x_i >>> SHIFT;
    ys   = y_i >>> SHIFT;
    step = signed'({{(ANG_W-ATAN_W){1'b0}}, atan_q20(5'(SHIFT))});
    if (y_i > 0) begin
      x_nxt   = x_i + ys;
      y_nxt   = y_i - xs;
      ang_nxt = ang_i + step;
    end else begin
      x_nxt   = x_i - ys;
      y_nxt   = y_i + xs;
      ang_nxt = ang_i - step;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign ang_o   = ang_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vtyp_mag_scale.sv =====
// two-stage gain correction of the planar magnitude, builds pitch pass inputs
// depends on vtyp_pkg (inverse gain, guard shift)
`timescale 1ns / 1ps
`default_nettype none

module vtyp_mag_scale
  import vtyp_pkg::*;
#(
  parameter int unsigned CW = 31,
  parameter int unsigned ZW = 24,
  parameter int unsigned SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] px_o,
  output logic signed [CW-1:0] py_o,
  output logic [SW-1:0]        side_o
);

  localparam int unsigned PW = CW - 1 + GAIN_W;

  logic                 v1_r, v2_r;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic signed [CW-1:0] pz_r, pz_nxt;
  logic [SW-1:0]        side1_r, side2_r;
  logic signed [CW-1:0] px_r, px_nxt, py_r;
  logic [CW-2:0]        mag_u;
  logic signed [CW-1:0] z_ext;
  logic [PW-1:0]        rnd;

  // stage one: clamp magnitude, multiply by inverse gain, scale and negate z
  always_comb begin
    mag_u    = (x_i > 0) ? x_i[CW-2:0] : '0;
    prod_nxt = {{GAIN_W{1'b0}}, mag_u} * {{(CW-1){1'b0}}, INV_GAIN};
    z_ext    = {{(CW-ZW){z_i[ZW-1]}}, z_i};
    pz_nxt   = -(z_ext <<< GUARD_SHIFT);
  end

  // stage two: round the q24 product back to integer scale
  always_comb begin
    rnd    = prod_r + PW'(1 << (GAIN_FRAC - 1));
    px_nxt = signed'({1'b0, rnd[PW-1:GAIN_FRAC]});
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      pz_r    <= pz_nxt;
      side1_r <= side_i;
      px_r    <= px_nxt;
      py_r    <= pz_r;
      side2_r <= side1_r;
    end
  end

  assign valid_o = v2_r;
  assign px_o    = px_r;
  assign py_o    = py_r;
  assign side_o  = side2_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vector_to_yaw_pitch.sv =====
// vector_to_yaw_pitch: direction vector to yaw and pitch angles in degrees
//
// Input beat (in_valid / in_stall / in_beat) carries signed x, y, z components.
// Output beat (out_valid / out_stall / out_beat) carries yaw and pitch as
// unsigned q9.16 degrees in [0, 360). One output beat per input beat, in order.
// The stages are an input register, the unrolled yaw cordic chain, two
// gain-correction stages, the unrolled pitch cordic chain and the output
// register. Throughput is one beat every cycle while the output is not stalled.
// Planar-zero vectors give yaw 0 and pitch 90 (270 when z is positive).
// Reset clears every valid bit; the pipeline is empty afterwards.
// When the output holds a beat and out_stall is high, the whole pipeline holds
// and in_stall goes high in the same cycle; no beat is lost or repeated.
// Depends on vtyp_pkg, vtyp_cordic_stage, vtyp_mag_scale.
`timescale 1ns / 1ps
`default_nettype none

module vector_to_yaw_pitch
  import vtyp_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int unsigned CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  typedef struct packed {
    logic planar_zero;
    logic y_zero;
    logic x_neg;
    logic z_zero;
    logic z_pos;
  } flags_t;

  localparam int unsigned CW     = COMPONENT_BITS + GUARD_SHIFT + 3;
  localparam int unsigned FLAG_W = $bits(flags_t);
  localparam int unsigned YSW    = COMPONENT_BITS + FLAG_W;
  localparam int unsigned PSW    = OUT_W + FLAG_W;

  // low component bits of the raw field, sign extended to datapath width
  function automatic logic signed [CW-1:0] sext(input logic [IN_W-1:0] f);
    logic [31:0]               e;
    logic [COMPONENT_BITS-1:0] v;
    e = {{(32-IN_W){1'b0}}, f};
    v = e[COMPONENT_BITS-1:0];
    return signed'({{(CW-COMPONENT_BITS){v[COMPONENT_BITS-1]}}, v});
  endfunction

  logic en;

  // input stage
  logic                    s0_valid_r;
  logic signed [CW-1:0]    s0_x_r, s0_y_r, x0_nxt, y0_nxt;
  logic signed [ANG_W-1:0] s0_ang_r, ang0_nxt;
  logic [YSW-1:0]          s0_side_r, side0_nxt;
  logic signed [CW-1:0]    sx, sy, sz, gx, gy;
  flags_t                  f0;

  // yaw chain
  logic                    yv   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    yx   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    yy   [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] ya   [0:CORDIC_STAGES];
  logic [YSW-1:0]          ys   [0:CORDIC_STAGES];

  // pitch chain
  logic                    pv   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    px   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    py   [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] pa   [0:CORDIC_STAGES];
  logic [PSW-1:0]          ps   [0:CORDIC_STAGES];

  flags_t                  yaw_flags, pitch_flags;
  logic [COMPONENT_BITS-1:0] yaw_z;
  logic [OUT_W-1:0]        yaw_fin, pitch_yaw, pitch_fin;

  logic      out_valid_r;
  out_beat_t out_beat_r, out_beat_nxt;

  // global advance: hold everything while a result waits on a stalled receiver
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // sign extend, guard shift, turn left half plane by 180 degrees
  always_comb begin
    sx = sext(in_beat.dir_x);
    sy = sext(in_beat.dir_y);
    sz = sext(in_beat.dir_z);
    gx = sx <<< GUARD_SHIFT;
    gy = sy <<< GUARD_SHIFT;
    f0.planar_zero = (sx == '0) && (sy == '0);
    f0.y_zero      = (sy == '0);
    f0.x_neg       = (sx < 0);
    f0.z_zero      = (sz == '0);
    f0.z_pos       = (sz > 0);
    if (sx < 0) begin
      x0_nxt   = -gx;
      y0_nxt   = -gy;
      ang0_nxt = ANG_180;
    end else begin
      x0_nxt   = gx;
      y0_nxt   = gy;
      ang0_nxt = '0;
    end
    side0_nxt = {sz[COMPONENT_BITS-1:0], f0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r    <= x0_nxt;
      s0_y_r    <= y0_nxt;
      s0_ang_r  <= ang0_nxt;
      s0_side_r <= side0_nxt;
    end
  end

  // yaw and magnitude pass
  assign yv[0] = s0_valid_r;
  assign yx[0] = s0_x_r;
  assign yy[0] = s0_y_r;
  assign ya[0] = s0_ang_r;
  assign ys[0] = s0_side_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
    vtyp_cordic_stage #(
      .CW    (CW),
      .SW    (YSW),
      .SHIFT (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (yv[i]),
      .x_i     (yx[i]),
      .y_i     (yy[i]),
      .ang_i   (ya[i]),
      .side_i  (ys[i]),
      .valid_o (yv[i+1]),
      .x_o     (yx[i+1]),
      .y_o     (yy[i+1]),
      .ang_o   (ya[i+1]),
      .side_o  (ys[i+1])
    );
  end

  // yaw result with axis and origin cases
  always_comb begin
    yaw_flags = flags_t'(ys[CORDIC_STAGES][FLAG_W-1:0]);
    yaw_z     = ys[CORDIC_STAGES][YSW-1:FLAG_W];
    if (yaw_flags.planar_zero) begin
      yaw_fin = '0;
    end else if (yaw_flags.y_zero) begin
      yaw_fin = yaw_flags.x_neg ? DEG_180 : '0;
    end else begin
      yaw_fin = finish_angle(ya[CORDIC_STAGES]);
    end
  end

  // gain correction and pitch pass setup
  vtyp_mag_scale #(
    .CW (CW),
    .ZW (COMPONENT_BITS),
    .SW (PSW)
  ) u_mag_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (yv[CORDIC_STAGES]),
    .x_i     (yx[CORDIC_STAGES]),
    .z_i     (signed'(yaw_z)),
    .side_i  ({yaw_fin, yaw_flags}),
    .valid_o (pv[0]),
    .px_o    (px[0]),
    .py_o    (py[0]),
    .side_o  (ps[0])
  );

  assign pa[0] = '0;

  // pitch pass
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pitch
    vtyp_cordic_stage #(
      .CW    (CW),
      .SW    (PSW),
      .SHIFT (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (pv[i]),
      .x_i     (px[i]),
      .y_i     (py[i]),
      .ang_i   (pa[i]),
      .side_i  (ps[i]),
      .valid_o (pv[i+1]),
      .x_o     (px[i+1]),
      .y_o     (py[i+1]),
      .ang_o   (pa[i+1]),
      .side_o  (ps[i+1])
    );
  end

  // pitch result with level and vertical cases
  always_comb begin
    pitch_flags = flags_t'(ps[CORDIC_STAGES][FLAG_W-1:0]);
    pitch_yaw   = ps[CORDIC_STAGES][PSW-1:FLAG_W];
    if (pitch_flags.planar_zero) begin
      pitch_fin = pitch_flags.z_pos ? DEG_270 : DEG_90;
    end else if (pitch_flags.z_zero) begin
      pitch_fin = '0;
    end else begin
      pitch_fin = finish_angle(pa[CORDIC_STAGES]);
    end
    out_beat_nxt.yaw_deg   = pitch_yaw;
    out_beat_nxt.pitch_deg = pitch_fin;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vtyp_checker.sv =====
// port-level checks for vector_to_yaw_pitch, bound to the top level
// depends on vtyp_pkg and vector_to_yaw_pitch_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "vector_to_yaw_pitch_macros.svh"

module vtyp_checker
  import vtyp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  logic angles_in_turn;

  // both output angles below one full turn
  assign angles_in_turn = (out_beat.yaw_deg < FULL_TURN_OUT) &&
                          (out_beat.pitch_deg < FULL_TURN_OUT);

  // a stalled output beat stays offered
  `VTYP_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)

  // a stalled output beat keeps its payload
  `VTYP_ASSERT_NEXT(a_out_beat_hold, out_valid && out_stall, $stable(out_beat))

  // input side only stalls while a result waits on a stalled receiver
  `VTYP_ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall)

  // both angles lie within one turn
  `VTYP_ASSERT_SAME(a_angle_range, out_valid, angles_in_turn)

endmodule

bind vector_to_yaw_pitch vtyp_checker u_vtyp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

`default_nettype wire

// ===== verif/tb_vector_to_yaw_pitch.sv =====
// testbench for vector_to_yaw_pitch: streams direction vectors and checks
// yaw and pitch against a cordic predictor held in a scoreboard class
// depends on vtyp_pkg and the vector_to_yaw_pitch rtl
`timescale 1ns / 1ps

module tb_vector_to_yaw_pitch;
  import vtyp_pkg::*;

  localparam int unsigned COMP_BITS = 24;
  localparam int unsigned STAGES    = 20;
  localparam int          NUM_RANDOM = 1900;
  localparam int          QUIET_FROM = 1600;
  localparam int          HOLD_CYCLES = 300;
  localparam int          COMP_MIN = -8388608;
  localparam int          COMP_MAX = 8388607;

  // fixed point scales of the datapath
  localparam longint GUARD      = 16;
  localparam longint HALF_TURN_Q20 = longint'(180) << 20;
  localparam longint TURN_Q16   = longint'(360) * 65536;
  localparam longint DEG90_Q16  = longint'(90) * 65536;
  localparam longint DEG180_Q16 = longint'(180) * 65536;
  localparam longint DEG270_Q16 = longint'(270) * 65536;
  localparam longint GAIN_Q24   = 10188014;

  // atan(2^-i) in degrees, q20
  localparam longint ATAN_STEP [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  // expected angles and their comparison against the output beats
  class angle_scoreboard;
    out_beat_t   expected_q[$];
    int unsigned mismatches;
    int unsigned matched;

    // vectoring pass: drives vy toward zero, returns the summed angle
    function automatic longint rotate_to_axis(inout longint vx, inout longint vy,
                                              input longint ang0);
      longint sx;
      longint sy;
      longint ang;
      ang = ang0;
      for (int i = 0; i < STAGES; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy > 0) begin
          vx  = vx + sy;
          vy  = vy - sx;
          ang = ang + ATAN_STEP[i];
        end else begin
          vx  = vx - sy;
          vy  = vy + sx;
          ang = ang - ATAN_STEP[i];
        end
      end
      return ang;
    endfunction

    // q20 degrees to q16 with rounding, then into one turn
    function automatic longint wrap_degrees(input longint ang);
      longint a;
      a = (ang + 8) >>> 4;
      if (a < 0) a = a + TURN_Q16;
      if (a >= TURN_Q16) a = a - TURN_Q16;
      if (a < 0 || a >= TURN_Q16) a = 0;
      return a;
    endfunction

    function automatic out_beat_t predict_angles(input in_beat_t b);
      longint    x, y, z;
      longint    cx, cy, px, py, start, ang, yaw, pitch;
      longint unsigned mag;
      out_beat_t r;
      x = longint'($signed(b.dir_x));
      y = longint'($signed(b.dir_y));
      z = longint'($signed(b.dir_z));
      if (x == 0 && y == 0) begin
        yaw   = 0;
        pitch = (z > 0) ? DEG270_Q16 : DEG90_Q16;
      end else begin
        cx    = x * GUARD;
        cy    = y * GUARD;
        start = 0;
        // left half plane: turn by 180 first
        if (cx < 0) begin
          cx    = -cx;
          cy    = -cy;
          start = HALF_TURN_Q20;
        end
        ang = rotate_to_axis(cx, cy, start);
        if (y == 0) yaw = (x > 0) ? 0 : DEG180_Q16;
        else yaw = wrap_degrees(ang);
        // planar magnitude with the cordic gain removed
        mag = (cx > 0) ? longint'(cx) : 0;
        mag = (mag * GAIN_Q24 + (64'd1 << 23)) >> 24;
        if (z == 0) begin
          pitch = 0;
        end else begin
          px    = longint'(mag);
          py    = -z * GUARD;
          pitch = wrap_degrees(rotate_to_axis(px, py, 0));
        end
      end
      r.yaw_deg   = OUT_W'(yaw);
      r.pitch_deg = OUT_W'(pitch);
      return r;
    endfunction

    function void note_input(input in_beat_t b);
      expected_q.push_back(predict_angles(b));
    endfunction

    function void check_result(input out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output beat: yaw_deg %0d pitch_deg %0d",
               got.yaw_deg, got.pitch_deg);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.yaw_deg !== want.yaw_deg) begin
        $error("yaw_deg: expected %0d, actual %0d", want.yaw_deg, got.yaw_deg);
        mismatches++;
      end
      if (got.pitch_deg !== want.pitch_deg) begin
        $error("pitch_deg: expected %0d, actual %0d", want.pitch_deg, got.pitch_deg);
        mismatches++;
      end
      matched++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;
  bit        quiet_tail;
  bit        hold_done;

  angle_scoreboard sb = new();

  vector_to_yaw_pitch #(
    .COMPONENT_BITS (COMP_BITS),
    .CORDIC_STAGES  (STAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one beat and wait until the block takes it
  task automatic send_beat(input in_beat_t b);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    in_beat_t b;
    b.dir_x = IN_W'(x);
    b.dir_y = IN_W'(y);
    b.dir_z = IN_W'(z);
    send_beat(b);
  endtask

  task automatic pause_source(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  function automatic int pick_corner();
    case ($urandom_range(0, 4))
      0:       return COMP_MIN;
      1:       return COMP_MAX;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // random vector, weighted toward axes, zero parts and corners
  function automatic in_beat_t draw_vector();
    in_beat_t    b;
    int unsigned kind;
    int          t;
    kind    = $urandom_range(0, 11);
    b.dir_x = IN_W'($urandom);
    b.dir_y = IN_W'($urandom);
    b.dir_z = IN_W'($urandom);
    case (kind)
      5: begin
        t = $urandom_range(0, 32); b.dir_x = IN_W'(t - 16);
        t = $urandom_range(0, 32); b.dir_y = IN_W'(t - 16);
        t = $urandom_range(0, 32); b.dir_z = IN_W'(t - 16);
      end
      6: begin
        b.dir_x = '0;
        b.dir_y = '0;
      end
      7: b.dir_y = '0;
      8: b.dir_z = '0;
      9: b.dir_x = '0;
      10: begin
        b.dir_x = IN_W'(pick_corner());
        b.dir_y = IN_W'(pick_corner());
        b.dir_z = IN_W'(pick_corner());
      end
      default: ;
    endcase
    return b;
  endfunction

  // output sampling
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_beat);
  end

  // receiver: stall bursts, one long hold, then none at the end
  initial begin
    int n;
    bit stall_on;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else if (!hold_done && sb.matched >= 150) begin
        // long hold so the pipeline fills and backs up the input
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        n        = $urandom_range(1, 15);
        stall_on = ($urandom_range(0, 2) == 0);
        repeat (n) begin
          @(negedge clk);
          out_stall <= stall_on;
        end
      end
    end
  end

  // sender: reset, directed vectors, random vectors, drain
  initial begin
    in_beat_t b;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_beat    = '0;
    quiet_tail = 1'b0;
    hold_done  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero planar part, z sign picks 90 or 270
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 1);
    send_xyz(0, 0, -1);
    send_xyz(0, 0, COMP_MAX);
    send_xyz(0, 0, COMP_MIN);
    // on the x axis, both signs, and level vectors
    send_xyz(1, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(COMP_MAX, 0, 0);
    send_xyz(COMP_MIN, 0, 0);
    send_xyz(COMP_MIN, 0, COMP_MAX);
    send_xyz(100, -100, 0);
    send_xyz(COMP_MIN, 1, 0);
    // on the y axis
    send_xyz(0, 1, 0);
    send_xyz(0, -1, 5);
    send_xyz(0, COMP_MIN, COMP_MIN);
    // corners and negative x in general position
    send_xyz(COMP_MAX, COMP_MAX, COMP_MAX);
    send_xyz(COMP_MIN, COMP_MIN, COMP_MIN);
    send_xyz(COMP_MIN, COMP_MAX, COMP_MIN);
    send_xyz(COMP_MAX, COMP_MIN, COMP_MAX);
    send_xyz(-5, 3, 7);
    send_xyz(1, 1, COMP_MIN);
    send_xyz(-1, -1, 1);
    send_xyz(3, 4, 5);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 3) == 0) pause_source($urandom_range(1, 15));
      b = draw_vector();
      send_beat(b);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // wait for the pipeline to empty, then allow for stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * STAGES + 20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vtyp_pkg.sv
hw/rtl/vtyp_cordic_stage.sv
hw/rtl/vtyp_mag_scale.sv
hw/rtl/vector_to_yaw_pitch.sv
hw/rtl/vtyp_checker.sv
verif/tb_vector_to_yaw_pitch.sv
